// ===== rtl/spiral_order_scan_unit_defines.svh =====
// ---------------------------------------------------------------------------
// spiral_order_scan_unit_defines
// Assertion macros used by the spiral scan walker.
// ---------------------------------------------------------------------------
`ifndef SPIRAL_ORDER_SCAN_UNIT_DEFINES_SVH
`define SPIRAL_ORDER_SCAN_UNIT_DEFINES_SVH

// same-cycle implication, disabled in reset
`define SOSU_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("spiral scan check failed");

// next-cycle implication, disabled in reset
`define SOSU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("spiral scan check failed");

`endif

// ===== rtl/sosu_pkg.sv =====
// ---------------------------------------------------------------------------
// sosu_pkg
// Shared types and constants of the spiral order scan unit.
// ---------------------------------------------------------------------------
package sosu_pkg;

    // width of the size registers
    localparam int SIZE_W = 4;
    // width of the element and result value ports
    localparam int FIELD_W = 32;
    // width of the configuration register index
    localparam int CFG_IDX_W = 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROW_COUNT    = 1'b0,
        CFG_COLUMN_COUNT = 1'b1
    } cfg_index_t;

    // walker status toward the top level
    typedef struct packed {
        logic active;   // a read is issued this cycle
        logic last;     // this read is the final spiral position
    } walk_t;

endpackage

// ===== rtl/sosu_store.sv =====
// ---------------------------------------------------------------------------
// sosu_store
// Element memory: one write port, one read port, registered read data.
// ---------------------------------------------------------------------------
module sosu_store #(
    parameter int DEPTH      = 64,
    parameter int ADDR_W     = 6,
    parameter int DATA_WIDTH = 32
) (
    input  logic                  clk,
    input  logic                  wr_en,
    input  logic [ADDR_W-1:0]     wr_addr,
    input  logic [DATA_WIDTH-1:0] wr_data,
    input  logic                  rd_en,
    input  logic [ADDR_W-1:0]     rd_addr,
    output logic [DATA_WIDTH-1:0] rd_data
);

    logic [DATA_WIDTH-1:0] mem [DEPTH];
    logic [DATA_WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/sosu_walker.sv =====
// ---------------------------------------------------------------------------
// sosu_walker
// Spiral address sequencer: walks the matrix clockwise from the top-left
// corner and issues one store read per cycle.
// ---------------------------------------------------------------------------
`include "spiral_order_scan_unit_defines.svh"

module sosu_walker #(
    parameter int MAX_ROWS    = 8,
    parameter int MAX_COLUMNS = 8,
    parameter int ADDR_W      = 6
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        go,
    input  logic [sosu_pkg::SIZE_W-1:0] rows,
    input  logic [sosu_pkg::SIZE_W-1:0] cols,
    input  logic [ADDR_W-1:0]           last_index,
    output logic [ADDR_W-1:0]           rd_addr,
    output sosu_pkg::walk_t             status
);

    localparam int RIDX_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CIDX_W = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int SUM_W  = RIDX_W + sosu_pkg::SIZE_W + 1;

    typedef enum logic [1:0] {
        DIR_RIGHT,
        DIR_DOWN,
        DIR_LEFT,
        DIR_UP
    } dir_t;

    dir_t              dir_reg;
    logic              active_reg;
    logic [ADDR_W-1:0] count_reg;
    logic [RIDX_W-1:0] row_reg, top_reg, bottom_reg;
    logic [CIDX_W-1:0] col_reg, left_reg, right_reg;
    logic              at_last;
    logic [SUM_W-1:0]  addr_sum;

    assign at_last  = (count_reg == last_index);
    assign addr_sum = SUM_W'(row_reg * cols) + SUM_W'(col_reg);
    assign rd_addr  = addr_sum[ADDR_W-1:0];

    assign status.active = active_reg;
    assign status.last   = at_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            dir_reg    <= DIR_RIGHT;
            count_reg  <= '0;
            row_reg    <= '0;
            col_reg    <= '0;
            top_reg    <= '0;
            bottom_reg <= '0;
            left_reg   <= '0;
            right_reg  <= '0;
        end
        else if (go)
        begin
            active_reg <= 1'b1;
            dir_reg    <= DIR_RIGHT;
            count_reg  <= '0;
            row_reg    <= '0;
            col_reg    <= '0;
            top_reg    <= '0;
            bottom_reg <= RIDX_W'(rows - sosu_pkg::SIZE_W'(1));
            left_reg   <= '0;
            right_reg  <= CIDX_W'(cols - sosu_pkg::SIZE_W'(1));
        end
        else if (active_reg)
        begin
            count_reg <= count_reg + ADDR_W'(1);
            if (at_last)
            begin
                active_reg <= 1'b0;
            end
            else
            begin
                // turn at the edge of the remaining band and shrink it
                unique case (dir_reg)
                    DIR_RIGHT:
                    begin
                        if (col_reg == right_reg)
                        begin
                            top_reg <= top_reg + RIDX_W'(1);
                            row_reg <= row_reg + RIDX_W'(1);
                            dir_reg <= DIR_DOWN;
                        end
                        else
                        begin
                            col_reg <= col_reg + CIDX_W'(1);
                        end
                    end
                    DIR_DOWN:
                    begin
                        if (row_reg == bottom_reg)
                        begin
                            right_reg <= right_reg - CIDX_W'(1);
                            col_reg   <= col_reg - CIDX_W'(1);
                            dir_reg   <= DIR_LEFT;
                        end
                        else
                        begin
                            row_reg <= row_reg + RIDX_W'(1);
                        end
                    end
                    DIR_LEFT:
                    begin
                        if (col_reg == left_reg)
                        begin
                            bottom_reg <= bottom_reg - RIDX_W'(1);
                            row_reg    <= row_reg - RIDX_W'(1);
                            dir_reg    <= DIR_UP;
                        end
                        else
                        begin
                            col_reg <= col_reg - CIDX_W'(1);
                        end
                    end
                    DIR_UP:
                    begin
                        if (row_reg == top_reg)
                        begin
                            left_reg <= left_reg + CIDX_W'(1);
                            col_reg  <= col_reg + CIDX_W'(1);
                            dir_reg  <= DIR_RIGHT;
                        end
                        else
                        begin
                            row_reg <= row_reg - RIDX_W'(1);
                        end
                    end
                    default:
                    begin
                        dir_reg <= DIR_RIGHT;
                    end
                endcase
            end
        end
    end

    `SOSU_ASSERT_IMPL(a_no_go_while_active, clk, rst_n, go, !active_reg)
    `SOSU_ASSERT_NEXT(a_go_starts_walk, clk, rst_n, go, active_reg && (count_reg == '0))
    `SOSU_ASSERT_NEXT(a_last_ends_walk, clk, rst_n, active_reg && at_last, !active_reg)
    `SOSU_ASSERT_NEXT(a_walk_continues, clk, rst_n, active_reg && !at_last && !go, active_reg)

endmodule

// ===== rtl/spiral_order_scan_unit.sv =====
// ---------------------------------------------------------------------------
// spiral_order_scan_unit
// Loads a matrix in row-major order and plays it back in clockwise spiral
// order from the top-left corner.
// ---------------------------------------------------------------------------
// Elements are taken one per cycle while busy is low. The beat that completes
// the matrix (rows*cols elements, sizes from the row_count and column_count
// registers, clamped to 1..MAX) raises busy in the next cycle; while busy is
// high the walker issues one read per cycle, rows*cols reads in all, to the
// single element memory port. Each result leaves in the cycle after its read,
// so the results form one unbroken run of rows*cols strobes, the first one
// leaving after the completing beat by way of the walker's active_reg and then
// strobe_reg, with last_of_run on the final one. A whole matrix is loaded as
// rows*cols elements and then scanned as rows*cols reads. Results cannot be
// held off; the receiver must take each strobe. start may rise again as soon
// as busy is low, while the last result is still on the ports.
module spiral_order_scan_unit #(
    parameter int MAX_ROWS    = 8,
    parameter int MAX_COLUMNS = 8,
    parameter int DATA_WIDTH  = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [sosu_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [sosu_pkg::SIZE_W-1:0]    cfg_data,
    input  logic                           start,
    output logic                           busy,
    input  logic [sosu_pkg::FIELD_W-1:0]   element_value,
    output logic                           result_strobe,
    output logic [sosu_pkg::FIELD_W-1:0]   spiral_value,
    output logic                           last_of_run
);

    localparam int DEPTH  = MAX_ROWS * MAX_COLUMNS;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int POS_W  = $clog2(DEPTH + 1);
    localparam int PROD_W = 2 * sosu_pkg::SIZE_W;

    logic [sosu_pkg::SIZE_W-1:0] row_count_reg, column_count_reg;
    logic [sosu_pkg::SIZE_W-1:0] rows, cols;
    logic [PROD_W-1:0]           total;
    logic [POS_W-1:0]            load_position_reg, pos_inc;
    logic                        accept, complete;
    logic [DATA_WIDTH-1:0]       wr_data, rd_data;
    logic [ADDR_W-1:0]           rd_addr;
    logic [ADDR_W-1:0]           last_index;
    logic signed [63:0]          value_wide;
    logic                        strobe_reg, last_reg;
    sosu_pkg::walk_t             walk;

    // clamp sizes to 1..MAX
    always_comb
    begin
        priority if (row_count_reg == '0)
            rows = sosu_pkg::SIZE_W'(1);
        else if (row_count_reg > sosu_pkg::SIZE_W'(MAX_ROWS))
            rows = sosu_pkg::SIZE_W'(MAX_ROWS);
        else
            rows = row_count_reg;

        priority if (column_count_reg == '0)
            cols = sosu_pkg::SIZE_W'(1);
        else if (column_count_reg > sosu_pkg::SIZE_W'(MAX_COLUMNS))
            cols = sosu_pkg::SIZE_W'(MAX_COLUMNS);
        else
            cols = column_count_reg;
    end

    assign total      = PROD_W'(rows * cols);
    assign last_index = ADDR_W'(total - PROD_W'(1));
    assign accept     = start && !busy;
    assign pos_inc    = load_position_reg + POS_W'(1);
    assign complete   = (PROD_W'(pos_inc) >= total);
    assign busy       = walk.active;
    assign wr_data    = DATA_WIDTH'(64'(element_value));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg    <= sosu_pkg::SIZE_W'(1);
            column_count_reg <= sosu_pkg::SIZE_W'(1);
        end
        else if (cfg_wr_en)
        begin
            unique case (sosu_pkg::cfg_index_t'(cfg_index))
                sosu_pkg::CFG_ROW_COUNT:    row_count_reg    <= cfg_data;
                sosu_pkg::CFG_COLUMN_COUNT: column_count_reg <= cfg_data;
                default:                    row_count_reg    <= row_count_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_position_reg <= '0;
        end
        else if (accept)
        begin
            load_position_reg <= complete ? '0 : pos_inc;
        end
    end

    sosu_store #(
        .DEPTH      (DEPTH),
        .ADDR_W     (ADDR_W),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (accept),
        .wr_addr (load_position_reg[ADDR_W-1:0]),
        .wr_data (wr_data),
        .rd_en   (walk.active),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    sosu_walker #(
        .MAX_ROWS    (MAX_ROWS),
        .MAX_COLUMNS (MAX_COLUMNS),
        .ADDR_W      (ADDR_W)
    ) u_walker (
        .clk        (clk),
        .rst_n      (rst_n),
        .go         (accept && complete),
        .rows       (rows),
        .cols       (cols),
        .last_index (last_index),
        .rd_addr    (rd_addr),
        .status     (walk)
    );

    // flags follow the read in the next cycle, aligned with the read data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strobe_reg <= 1'b0;
            last_reg   <= 1'b0;
        end
        else
        begin
            strobe_reg <= walk.active;
            last_reg   <= walk.active && walk.last;
        end
    end

    assign value_wide    = 64'(signed'(rd_data));
    assign spiral_value  = value_wide[sosu_pkg::FIELD_W-1:0];
    assign result_strobe = strobe_reg;
    assign last_of_run   = last_reg;

endmodule

// ===== tb/spiral_scan_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// spiral_scan_checker
// Watches the load, configuration and result ports of the spiral order scan
// unit, keeps its own copy of the matrix and size registers, predicts the
// spiral readout of every completed matrix and compares each result beat.
// ---------------------------------------------------------------------------
module spiral_scan_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [sosu_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [sosu_pkg::SIZE_W-1:0]    cfg_data,
    input  logic                           start,
    input  logic                           busy,
    input  logic [sosu_pkg::FIELD_W-1:0]   element_value,
    input  logic                           result_strobe,
    input  logic [sosu_pkg::FIELD_W-1:0]   spiral_value,
    input  logic                           last_of_run,
    output int                             fail_count,
    output int                             pending_count
);

    localparam int MAX_ROWS    = 8;
    localparam int MAX_COLUMNS = 8;
    localparam int STORE_DEPTH = 64;

    typedef struct packed {
        logic [sosu_pkg::FIELD_W-1:0] value;
        logic                         last;
    } spiral_beat_t;

    spiral_beat_t                 expected_spiral[$];
    logic [sosu_pkg::FIELD_W-1:0] matrix_store[STORE_DEPTH];
    logic [6:0]                   load_pos;
    logic [sosu_pkg::SIZE_W-1:0]  row_reg;
    logic [sosu_pkg::SIZE_W-1:0]  col_reg;
    int                           errors;
    int                           cells_queued;
    int                           cells_total;

    function automatic int clamp_dim(input logic [sosu_pkg::SIZE_W-1:0] v,
                                     input int max_dim);
        if (v == 0)
            return 1;
        if (int'(v) > max_dim)
            return max_dim;
        return int'(v);
    endfunction

    function automatic void queue_cell(input int r, input int c, input int cols);
        spiral_beat_t beat;
        beat.value = matrix_store[(r * cols + c) % STORE_DEPTH];
        cells_queued++;
        beat.last = (cells_queued == cells_total);
        expected_spiral = {expected_spiral, beat};
    endfunction

    // clockwise walk: top row, right column, bottom row, left column, shrink
    function automatic void predict_spiral(input int rows, input int cols);
        int top_r;
        int bot_r;
        int left_c;
        int right_c;
        int i;
        top_r = 0;
        bot_r = rows - 1;
        left_c = 0;
        right_c = cols - 1;
        cells_queued = 0;
        cells_total = rows * cols;
        while (top_r <= bot_r && left_c <= right_c)
        begin
            for (i = left_c; i <= right_c; i++)
                queue_cell(top_r, i, cols);
            top_r++;
            for (i = top_r; i <= bot_r; i++)
                queue_cell(i, right_c, cols);
            right_c--;
            if (top_r <= bot_r)
            begin
                for (i = right_c; i >= left_c; i--)
                    queue_cell(bot_r, i, cols);
                bot_r--;
            end
            if (left_c <= right_c)
            begin
                for (i = bot_r; i >= top_r; i--)
                    queue_cell(i, left_c, cols);
                left_c++;
            end
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        spiral_beat_t got;
        int rows;
        int cols;
        if (!rst_n)
        begin
            expected_spiral.delete();
            load_pos = '0;
            row_reg = sosu_pkg::SIZE_W'(1);
            col_reg = sosu_pkg::SIZE_W'(1);
            errors = 0;
            fail_count <= 0;
            pending_count <= 0;
        end
        else
        begin
            if (result_strobe)
            begin
                if (expected_spiral.size() == 0)
                begin
                    $display("%0t: unexpected result beat: expected none, actual %h last %b",
                             $time, spiral_value, last_of_run);
                    errors++;
                end
                else
                begin
                    got = expected_spiral.pop_front();
                    if (spiral_value !== got.value)
                    begin
                        $display("%0t: spiral_value mismatch: expected %h, actual %h",
                                 $time, got.value, spiral_value);
                        errors++;
                    end
                    if (last_of_run !== got.last)
                    begin
                        $display("%0t: last_of_run mismatch: expected %b, actual %b",
                                 $time, got.last, last_of_run);
                        errors++;
                    end
                end
            end

            if (cfg_wr_en)
            begin
                if (cfg_index == sosu_pkg::CFG_ROW_COUNT)
                    row_reg = cfg_data;
                else if (cfg_index == sosu_pkg::CFG_COLUMN_COUNT)
                    col_reg = cfg_data;
            end

            if (start && !busy)
            begin
                rows = clamp_dim(row_reg, MAX_ROWS);
                cols = clamp_dim(col_reg, MAX_COLUMNS);
                matrix_store[load_pos[5:0]] = element_value;
                load_pos = load_pos + 7'd1;
                // sizes may have shrunk mid-load, so test with >=
                if (int'(load_pos) >= rows * cols)
                begin
                    load_pos = '0;
                    predict_spiral(rows, cols);
                end
            end

            fail_count <= errors;
            pending_count <= expected_spiral.size();
        end
    end

endmodule

// ===== tb/tb_spiral_order_scan_unit.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_spiral_order_scan_unit
// Loads matrices of many shapes into the spiral order scan unit, among them
// single rows, single columns, clamped sizes and sizes changed mid-load, with
// random sender gaps; a checker beside the block predicts every readout.
// ---------------------------------------------------------------------------
module tb_spiral_order_scan_unit;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 4;

    logic                         clk;
    logic                         rst_n;
    logic                         cfg_wr_en;
    sosu_pkg::cfg_index_t         cfg_index;
    logic [sosu_pkg::SIZE_W-1:0]  cfg_data;
    logic                         start;
    logic                         busy;
    logic [sosu_pkg::FIELD_W-1:0] element_value;
    logic                         result_strobe;
    logic [sosu_pkg::FIELD_W-1:0] spiral_value;
    logic                         last_of_run;
    int                           fail_count;
    int                           pending_count;

    int                           sender_idle_pct;
    logic [sosu_pkg::SIZE_W-1:0]  cur_rows;
    logic [sosu_pkg::SIZE_W-1:0]  cur_cols;
    int                           stall_cycles;

    spiral_order_scan_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .start         (start),
        .busy          (busy),
        .element_value (element_value),
        .result_strobe (result_strobe),
        .spiral_value  (spiral_value),
        .last_of_run   (last_of_run)
    );

    spiral_scan_checker checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .start         (start),
        .busy          (busy),
        .element_value (element_value),
        .result_strobe (result_strobe),
        .spiral_value  (spiral_value),
        .last_of_run   (last_of_run),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int dim_in_use(input logic [sosu_pkg::SIZE_W-1:0] v);
        if (v == 0)
            return 1;
        if (v > 8)
            return 8;
        return int'(v);
    endfunction

    function automatic logic [sosu_pkg::FIELD_W-1:0] pick_element();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'h0000_0000;
            3: return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [sosu_pkg::SIZE_W-1:0] pick_size(input int lo, input int hi);
        return sosu_pkg::SIZE_W'($urandom_range(hi, lo));
    endfunction

    // one beat; start stays high on return so back-to-back beats need no gap
    task automatic send_element(input logic [sosu_pkg::FIELD_W-1:0] value);
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        element_value <= value;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic send_random(input int count);
        repeat (count)
            send_element(pick_element());
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_cfg(input sosu_pkg::cfg_index_t idx,
                             input logic [sosu_pkg::SIZE_W-1:0] value);
        start <= 1'b0;
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        @(posedge clk);
        if (idx == sosu_pkg::CFG_ROW_COUNT)
            cur_rows = value;
        else
            cur_cols = value;
    endtask

    task automatic run_phase(input int idle_pct, input int items);
        int sent;
        int total;
        int loaded;
        int rest;
        sender_idle_pct = idle_pct;
        sent = 0;
        while (sent < items)
        begin
            case ($urandom_range(0, 9))
                0:
                begin
                    write_cfg(sosu_pkg::CFG_ROW_COUNT, 4'd8);
                    write_cfg(sosu_pkg::CFG_COLUMN_COUNT, 4'd8);
                end
                1:
                begin
                    write_cfg(sosu_pkg::CFG_ROW_COUNT, 4'd1);
                    write_cfg(sosu_pkg::CFG_COLUMN_COUNT, 4'd1);
                end
                2:
                begin
                    write_cfg(sosu_pkg::CFG_ROW_COUNT, pick_size(0, 15));
                    write_cfg(sosu_pkg::CFG_COLUMN_COUNT, pick_size(0, 15));
                end
                default:
                begin
                    write_cfg(sosu_pkg::CFG_ROW_COUNT, pick_size(1, 4));
                    write_cfg(sosu_pkg::CFG_COLUMN_COUNT, pick_size(1, 4));
                end
            endcase
            total = dim_in_use(cur_rows) * dim_in_use(cur_cols);
            if (total > 1 && $urandom_range(0, 5) == 0)
            begin
                // resize part way through a load
                loaded = $urandom_range(1, total - 1);
                send_random(loaded);
                drain();
                if ($urandom_range(0, 1) == 0)
                    write_cfg(sosu_pkg::CFG_ROW_COUNT, pick_size(0, 15));
                else
                    write_cfg(sosu_pkg::CFG_COLUMN_COUNT, pick_size(0, 15));
                total = dim_in_use(cur_rows) * dim_in_use(cur_cols);
                rest = (loaded >= total) ? 1 : total - loaded;
                send_random(rest);
                sent += loaded + rest;
            end
            else
            begin
                send_random(total);
                sent += total;
            end
            drain();
        end
    endtask

    // watchdog: cycles with no beat on either side
    initial
    begin
        stall_cycles = 0;
        while (stall_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((start && !busy) || result_strobe)
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("FAILURE");
        $finish;
    end

    initial
    begin
        int i;
        rst_n <= 1'b0;
        start <= 1'b0;
        element_value <= '0;
        cfg_wr_en <= 1'b0;
        cfg_index <= sosu_pkg::CFG_ROW_COUNT;
        cfg_data <= '0;
        cur_rows = sosu_pkg::SIZE_W'(1);
        cur_cols = sosu_pkg::SIZE_W'(1);
        sender_idle_pct = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // 1x1 out of reset, extreme values
        send_element(32'h8000_0000);
        send_element(32'h7fff_ffff);
        drain();

        // zero row count acts as one: single row of three
        write_cfg(sosu_pkg::CFG_ROW_COUNT, 4'd0);
        write_cfg(sosu_pkg::CFG_COLUMN_COUNT, 4'd3);
        send_element(32'h0000_0000);
        send_element(32'hffff_ffff);
        send_element(32'h0000_0001);
        drain();

        // oversize row count clamps to eight: single column
        write_cfg(sosu_pkg::CFG_ROW_COUNT, 4'd15);
        write_cfg(sosu_pkg::CFG_COLUMN_COUNT, 4'd1);
        for (i = 0; i < 8; i++)
            send_element((i % 2 == 0) ? 32'haaaa_aaaa : 32'h5555_5555);
        drain();

        // 3x3: spiral reaches the center cell
        write_cfg(sosu_pkg::CFG_ROW_COUNT, 4'd3);
        write_cfg(sosu_pkg::CFG_COLUMN_COUNT, 4'd3);
        for (i = 1; i <= 9; i++)
            send_element(i);
        drain();

        // shrink mid-load to the count already loaded
        write_cfg(sosu_pkg::CFG_ROW_COUNT, 4'd2);
        write_cfg(sosu_pkg::CFG_COLUMN_COUNT, 4'd3);
        send_element(32'h1234_5678);
        send_element(32'h8765_4321);
        drain();
        write_cfg(sosu_pkg::CFG_COLUMN_COUNT, 4'd1);
        send_element(32'hdead_beef);
        drain();

        run_phase(9, 135);
        run_phase(65, 135);
        run_phase(0, 135);

        if (fail_count == 0 && pending_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
